@@ rtl/vrpa_pkg.sv @@
package vrpa_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned LaneCount = 4;
   localparam int unsigned RegCount = 128;
   localparam int unsigned PrefixWidth = 20;

   localparam logic [PrefixWidth-1:0] SrcPassPrefix = 20'h000E4;
   localparam logic [PrefixWidth-1:0] DstPassPrefix = 20'h00000;
   localparam logic [WordWidth-1:0] FloatOne = 32'h3F800000;
   localparam logic [WordWidth-1:0] FloatMinusOne = 32'hBF800000;
   localparam logic [WordWidth-1:0] FloatZero = 32'h00000000;
   localparam logic [WordWidth-1:0] FloatPosInf = 32'h7F800000;

   localparam logic [1:0] SatClampUnit = 2'd1;
   localparam logic [1:0] SatClampSigned = 2'd3;

   localparam logic ReqRead = 1'b0;
   localparam logic ReqWrite = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_RD_ISSUE,
      ST_RD_CAPTURE,
      ST_WRITE,
      ST_RESPOND
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic rd_issue;
      logic rd_capture;
      logic wr_lane;
      logic next_lane;
   } dp_cmd_type;

   typedef struct packed {
      logic is_write;
      logic last_lane;
   } dp_status_type;

   function automatic logic [WordWidth-1:0] src_constant(input logic [2:0] sel);
      logic [WordWidth-1:0] result;
      begin
         case (sel)
            3'd0: result = 32'h00000000;
            3'd1: result = 32'h3F800000;
            3'd2: result = 32'h40000000;
            3'd3: result = 32'h3F000000;
            3'd4: result = 32'h40400000;
            3'd5: result = 32'h3EAAAAAB;
            3'd6: result = 32'h3E800000;
            default: result = 32'h3E2AAAAB;
         endcase
         return result;
      end
   endfunction

endpackage

@@ rtl/vrpa_req_if.sv @@
interface vrpa_req_if;
   logic valid;
   logic ready;
   logic req_type;
   logic [6:0] vreg;
   logic [1:0] vec_size;
   logic [19:0] prefix_word;
   logic [31:0] in_elem0;
   logic [31:0] in_elem1;
   logic [31:0] in_elem2;
   logic [31:0] in_elem3;

   modport source (output valid, req_type, vreg, vec_size, prefix_word,
                   in_elem0, in_elem1, in_elem2, in_elem3, input ready);
   modport sink (input valid, req_type, vreg, vec_size, prefix_word,
                 in_elem0, in_elem1, in_elem2, in_elem3, output ready);
endinterface

@@ rtl/vrpa_rsp_if.sv @@
interface vrpa_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] out_elem0;
   logic [31:0] out_elem1;
   logic [31:0] out_elem2;
   logic [31:0] out_elem3;
   logic [2:0] lane_count;

   modport source (output valid, out_elem0, out_elem1, out_elem2, out_elem3,
                   lane_count, input ready);
   modport sink (input valid, out_elem0, out_elem1, out_elem2, out_elem3,
                 lane_count, output ready);
endinterface

@@ rtl/vector_register_prefix_access_top.sv @@
// Vector register file of 128 single-precision words with operand prefixes.
// The req_if channel carries one request: a read that applies the source
// prefix, or a write that applies the destination prefix and then stores.
// The rsp_if channel returns one result per request with lane_count lanes;
// lanes beyond the count are zero, and a write returns the stored values.
// Requests are taken one at a time: req_if.ready is high only while idle.
// A read issues and then captures each lane in turn, and a write stores one
// lane per step, after a dispatch state that decodes the request; the
// single-port word store gives one access per cycle and read data arrives
// in the cycle after its address.
// The result stays valid until the receiver takes it; while the receiver
// stalls, no new request is taken. Synchronous reset returns the controller
// to idle and clears the written flags, so every word reads as zero until
// it is written again; no clearing pass is needed.
module vector_register_prefix_access_top
   import vrpa_pkg::*;
(
   input logic clock,
   input logic reset,
   vrpa_req_if.sink req_if,
   vrpa_rsp_if.source rsp_if
);

   dp_cmd_type cmd;
   dp_status_type status;
   logic [WordWidth-1:0] in_elem [LaneCount];
   logic [WordWidth-1:0] out_elem [LaneCount];

   assign in_elem[0] = req_if.in_elem0;
   assign in_elem[1] = req_if.in_elem1;
   assign in_elem[2] = req_if.in_elem2;
   assign in_elem[3] = req_if.in_elem3;

   vrpa_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_if.valid),
      .req_ready(req_if.ready),
      .rsp_valid(rsp_if.valid),
      .rsp_ready(rsp_if.ready),
      .cmd(cmd),
      .status(status)
   );

   vrpa_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_type(req_if.req_type),
      .vreg(req_if.vreg),
      .vec_size(req_if.vec_size),
      .prefix_word(req_if.prefix_word),
      .in_elem(in_elem),
      .out_elem(out_elem),
      .lane_count(rsp_if.lane_count)
   );

   assign rsp_if.out_elem0 = out_elem[0];
   assign rsp_if.out_elem1 = out_elem[1];
   assign rsp_if.out_elem2 = out_elem[2];
   assign rsp_if.out_elem3 = out_elem[3];

endmodule

@@ rtl/vrpa_ctrl.sv @@
module vrpa_ctrl
   import vrpa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output dp_cmd_type cmd,
   input  dp_status_type status
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = status.is_write ? ST_WRITE : ST_RD_ISSUE;
         end
         ST_RD_ISSUE: begin
            cmd.rd_issue = 1'b1;
            state_in = ST_RD_CAPTURE;
         end
         ST_RD_CAPTURE: begin
            cmd.rd_capture = 1'b1;
            if (status.last_lane) begin
               state_in = ST_RESPOND;
            end else begin
               cmd.next_lane = 1'b1;
               state_in = ST_RD_ISSUE;
            end
         end
         ST_WRITE: begin
            cmd.wr_lane = 1'b1;
            if (status.last_lane) begin
               state_in = ST_RESPOND;
            end else begin
               cmd.next_lane = 1'b1;
            end
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/vrpa_datapath.sv @@
module vrpa_datapath
   import vrpa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  dp_cmd_type cmd,
   output dp_status_type status,
   input  logic req_type,
   input  logic [6:0] vreg,
   input  logic [1:0] vec_size,
   input  logic [PrefixWidth-1:0] prefix_word,
   input  logic [WordWidth-1:0] in_elem [LaneCount],
   output logic [WordWidth-1:0] out_elem [LaneCount],
   output logic [2:0] lane_count
);

   logic [WordWidth-1:0] mem [RegCount];
   logic [RegCount-1:0] written_ff;
   logic [WordWidth-1:0] rdata_ff;
   logic rvalid_ff;

   logic is_write_ff;
   logic [6:0] vreg_ff;
   logic [1:0] size_ff;
   logic [PrefixWidth-1:0] prefix_ff;
   logic [WordWidth-1:0] in_elem_ff [LaneCount];
   logic [WordWidth-1:0] lane_ff [LaneCount];
   logic [1:0] idx_ff;

   logic [1:0] row_base;
   logic [1:0] col_sum;
   logic [1:0] row_sum;
   logic [6:0] addr;
   logic [WordWidth-1:0] rd_word;
   logic [WordWidth-1:0] src_word;
   logic [WordWidth-1:0] dst_word;
   logic [WordWidth-1:0] wr_src;
   logic [1:0] sel_bits;
   logic abs_bit;
   logic const_bit;
   logic neg_bit;
   logic is_nan;
   logic above_one;
   logic below_zero;
   logic below_minus_one;

   always_comb begin
      case (size_ff)
         2'd0: row_base = vreg_ff[6:5];
         2'd2: row_base = {1'b0, vreg_ff[6]};
         default: row_base = {vreg_ff[6], 1'b0};
      endcase
      col_sum = vreg_ff[1:0] + idx_ff;
      row_sum = row_base + idx_ff;
      if (vreg_ff[5]) begin
         addr = {row_base, vreg_ff[4:2], col_sum};
      end else begin
         addr = {row_sum, vreg_ff[4:2], vreg_ff[1:0]};
      end
   end

   always_comb begin
      rd_word = rvalid_ff ? rdata_ff : FloatZero;
      sel_bits = prefix_ff[2*idx_ff +: 2];
      abs_bit = prefix_ff[5'd8 + 5'(idx_ff)];
      const_bit = prefix_ff[5'd12 + 5'(idx_ff)];
      neg_bit = prefix_ff[5'd16 + 5'(idx_ff)];
      if (prefix_ff == SrcPassPrefix) begin
         src_word = rd_word;
      end else begin
         if (const_bit) begin
            src_word = src_constant({abs_bit, sel_bits});
         end else begin
            src_word = abs_bit ? {1'b0, rd_word[WordWidth-2:0]} : rd_word;
         end
         src_word[WordWidth-1] = src_word[WordWidth-1] ^ neg_bit;
      end
   end

   always_comb begin
      wr_src = in_elem_ff[idx_ff];
      is_nan = wr_src[WordWidth-2:0] > FloatPosInf[WordWidth-2:0];
      above_one = !wr_src[WordWidth-1] && !is_nan
                  && (wr_src[WordWidth-2:0] > FloatOne[WordWidth-2:0]);
      below_zero = wr_src[WordWidth-1] && !is_nan && (wr_src[WordWidth-2:0] != '0);
      below_minus_one = wr_src[WordWidth-1] && !is_nan
                        && (wr_src[WordWidth-2:0] > FloatOne[WordWidth-2:0]);
      dst_word = wr_src;
      if (prefix_ff != DstPassPrefix) begin
         if (sel_bits == SatClampUnit) begin
            if (above_one) begin
               dst_word = FloatOne;
            end else if (below_zero) begin
               dst_word = FloatZero;
            end
         end else if (sel_bits == SatClampSigned) begin
            if (above_one) begin
               dst_word = FloatOne;
            end else if (below_minus_one) begin
               dst_word = FloatMinusOne;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_lane) begin
         mem[addr] <= dst_word;
      end
      if (cmd.rd_issue) begin
         rdata_ff <= mem[addr];
         rvalid_ff <= written_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (cmd.wr_lane) begin
         written_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_write_ff <= (req_type == ReqWrite);
         vreg_ff <= vreg;
         size_ff <= vec_size;
         prefix_ff <= prefix_word;
         idx_ff <= 2'd0;
         for (int n = 0; n < LaneCount; n++) begin
            in_elem_ff[n] <= in_elem[n];
            lane_ff[n] <= FloatZero;
         end
      end else begin
         if (cmd.rd_capture) begin
            lane_ff[idx_ff] <= src_word;
         end
         if (cmd.wr_lane) begin
            lane_ff[idx_ff] <= dst_word;
         end
         if (cmd.next_lane) begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   assign status = '{is_write: is_write_ff, last_lane: (idx_ff == size_ff)};
   assign out_elem = lane_ff;
   assign lane_count = {1'b0, size_ff} + 3'd1;

endmodule

@@ test/vrpa_checker.sv @@
`timescale 1ns / 1ps
module vrpa_checker
   import vrpa_pkg::*;
(
   input logic clock,
   input logic reset,
   vrpa_req_if.sink req_mon,
   vrpa_rsp_if.sink rsp_mon,
   output int unsigned error_count,
   output int unsigned pending_count,
   output int unsigned read_count,
   output int unsigned write_count
);

   typedef struct {
      logic [WordWidth-1:0] elem [LaneCount];
      logic [2:0] lanes;
   } vector_result_type;

   logic [WordWidth-1:0] shadow_file [RegCount];
   vector_result_type expected_vectors [$];

   function automatic logic [6:0] word_index(input logic [6:0] code, input logic [1:0] size,
                                             input int lane);
      logic [2:0] mat;
      logic [1:0] col;
      logic [1:0] row;
      begin
         mat = code[4:2];
         col = code[1:0];
         case (size)
            2'd0: row = code[6:5];
            2'd2: row = {1'b0, code[6]};
            default: row = {code[6], 1'b0};
         endcase
         if (code[5]) begin
            return {row, mat, 2'(col + lane)};
         end
         return {2'(row + lane), mat, col};
      end
   endfunction

   function automatic logic [WordWidth-1:0] clamp_word(input logic [WordWidth-1:0] w,
                                                      input logic signed_range);
      logic is_nan;
      begin
         is_nan = w[30:0] > 31'h7F800000;
         if (is_nan) begin
            return w;
         end
         if (!w[31] && w[30:0] > 31'h3F800000) begin
            return FloatOne;
         end
         if (w[31] && !signed_range && w[30:0] != 31'd0) begin
            return FloatZero;
         end
         if (w[31] && signed_range && w[30:0] > 31'h3F800000) begin
            return FloatMinusOne;
         end
         return w;
      end
   endfunction

   function automatic logic [WordWidth-1:0] const_word(input logic [2:0] sel);
      case (sel)
         3'd0: return 32'h00000000;
         3'd1: return 32'h3F800000;
         3'd2: return 32'h40000000;
         3'd3: return 32'h3F000000;
         3'd4: return 32'h40400000;
         3'd5: return 32'h3EAAAAAB;
         3'd6: return 32'h3E800000;
         default: return 32'h3E2AAAAB;
      endcase
   endfunction

   task automatic predict_vector();
      vector_result_type r;
      logic [WordWidth-1:0] in_w [LaneCount];
      logic [19:0] pfx;
      int k;
      begin
         in_w[0] = req_mon.in_elem0;
         in_w[1] = req_mon.in_elem1;
         in_w[2] = req_mon.in_elem2;
         in_w[3] = req_mon.in_elem3;
         pfx = req_mon.prefix_word;
         k = req_mon.vec_size + 1;
         for (int n = 0; n < LaneCount; n++) r.elem[n] = '0;
         r.lanes = 3'(k);
         if (req_mon.req_type == ReqRead) begin
            read_count++;
            for (int n = 0; n < k; n++) begin
               r.elem[n] = shadow_file[word_index(req_mon.vreg, req_mon.vec_size, n)];
               if (pfx != SrcPassPrefix) begin
                  if (pfx[12+n]) begin
                     r.elem[n] = const_word({pfx[8+n], pfx[2*n+1], pfx[2*n]});
                  end else if (pfx[8+n]) begin
                     r.elem[n][31] = 1'b0;
                  end
                  if (pfx[16+n]) begin
                     r.elem[n][31] = ~r.elem[n][31];
                  end
               end
            end
         end else begin
            write_count++;
            for (int n = 0; n < k; n++) begin
               r.elem[n] = in_w[n];
               if (pfx != DstPassPrefix) begin
                  if (pfx[2*n +: 2] == SatClampUnit) begin
                     r.elem[n] = clamp_word(in_w[n], 1'b0);
                  end else if (pfx[2*n +: 2] == SatClampSigned) begin
                     r.elem[n] = clamp_word(in_w[n], 1'b1);
                  end
               end
            end
            for (int n = 0; n < k; n++) begin
               shadow_file[word_index(req_mon.vreg, req_mon.vec_size, n)] = r.elem[n];
            end
         end
         expected_vectors.push_back(r);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      begin
         $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
         error_count++;
      end
   endtask

   task automatic compare_vector();
      vector_result_type r;
      logic [WordWidth-1:0] got [LaneCount];
      begin
         if (expected_vectors.size() == 0) begin
            report_mismatch("result transfer with nothing expected, lane_count",
                            32'(rsp_mon.lane_count), 32'd0);
         end else begin
            r = expected_vectors.pop_front();
            got[0] = rsp_mon.out_elem0;
            got[1] = rsp_mon.out_elem1;
            got[2] = rsp_mon.out_elem2;
            got[3] = rsp_mon.out_elem3;
            for (int n = 0; n < LaneCount; n++) begin
               if (got[n] !== r.elem[n]) begin
                  report_mismatch($sformatf("out_elem%0d", n), got[n], r.elem[n]);
               end
            end
            if (rsp_mon.lane_count !== r.lanes) begin
               report_mismatch("lane_count", 32'(rsp_mon.lane_count), 32'(r.lanes));
            end
         end
      end
   endtask

   initial begin
      error_count = 0;
      read_count = 0;
      write_count = 0;
      for (int i = 0; i < RegCount; i++) shadow_file[i] = '0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            compare_vector();
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            predict_vector();
         end
      end
   end

   assign pending_count = expected_vectors.size();

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import vrpa_pkg::*;

   localparam int unsigned RandomItems = 400;
   localparam int unsigned CycleLimit = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm = 1'b0;
   int unsigned cycles = 0;
   int unsigned stall_left = 0;
   int unsigned error_count;
   int unsigned pending_count;
   int unsigned read_count;
   int unsigned write_count;

   vrpa_req_if req_if ();
   vrpa_rsp_if rsp_if ();

   vector_register_prefix_access_top dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source)
   );

   vrpa_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_mon(req_if.sink),
      .rsp_mon(rsp_if.sink),
      .error_count(error_count),
      .pending_count(pending_count),
      .read_count(read_count),
      .write_count(write_count)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("Run stopped at the cycle limit.");
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The receiver stalls in random bursts until the calm part of the run.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_if.ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= $urandom_range(0, 13);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 11))
         0: return 32'h00000000;
         1: return 32'h80000000;
         2: return 32'h3F800000;
         3: return 32'hBF800000;
         4: return 32'h7F800000;
         5: return 32'hFF800000;
         6: return 32'h7FC00000 | ($urandom() & 32'h803FFFFF);
         7: return 32'h3F000000 | ($urandom() & 32'h80FFFFFF);
         8: return 32'h3F800000 + $urandom_range(1, 3) | ($urandom() & 32'h80000000);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_vector(input logic kind, input logic [6:0] code, input logic [1:0] size,
                              input logic [19:0] pfx, input logic [31:0] w0,
                              input logic [31:0] w1, input logic [31:0] w2,
                              input logic [31:0] w3);
      begin
         req_if.valid <= 1'b1;
         req_if.req_type <= kind;
         req_if.vreg <= code;
         req_if.vec_size <= size;
         req_if.prefix_word <= pfx;
         req_if.in_elem0 <= w0;
         req_if.in_elem1 <= w1;
         req_if.in_elem2 <= w2;
         req_if.in_elem3 <= w3;
         do @(posedge clock); while (req_if.ready !== 1'b1);
         if (!calm && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end
   endtask

   task automatic send_random();
      logic kind;
      logic [19:0] pfx;
      begin
         kind = $urandom_range(0, 1);
         if (kind == ReqRead) begin
            pfx = ($urandom_range(0, 3) == 0) ? SrcPassPrefix : 20'($urandom());
         end else begin
            pfx = ($urandom_range(0, 2) == 0) ? DstPassPrefix : 20'($urandom());
         end
         send_vector(kind, 7'($urandom()), 2'($urandom()), pfx, pick_word(), pick_word(),
                     pick_word(), pick_word());
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.req_type = ReqRead;
      req_if.vreg = '0;
      req_if.vec_size = '0;
      req_if.prefix_word = '0;
      req_if.in_elem0 = '0;
      req_if.in_elem1 = '0;
      req_if.in_elem2 = '0;
      req_if.in_elem3 = '0;
      rsp_if.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_vector(ReqRead, 7'h7F, 2'd3, SrcPassPrefix, '0, '0, '0, '0);
      send_vector(ReqWrite, 7'h00, 2'd3, DstPassPrefix, 32'hFFFFFFFF, 32'h80000000,
                  32'h7FC00001, 32'h3F800001);
      send_vector(ReqRead, 7'h00, 2'd3, SrcPassPrefix, '0, '0, '0, '0);
      send_vector(ReqRead, 7'h00, 2'd3, 20'h00F00, '0, '0, '0, '0);
      send_vector(ReqRead, 7'h00, 2'd3, 20'h0F000, '0, '0, '0, '0);
      send_vector(ReqRead, 7'h00, 2'd3, 20'h0FFFF, '0, '0, '0, '0);
      send_vector(ReqRead, 7'h00, 2'd3, 20'hF0000, '0, '0, '0, '0);
      send_vector(ReqRead, 7'h00, 2'd3, 20'hFFFFF, '0, '0, '0, '0);
      send_vector(ReqRead, 7'h00, 2'd3, 20'h0F0E4, '0, '0, '0, '0);
      send_vector(ReqWrite, 7'h23, 2'd3, 20'h00055, 32'h3FC00000, 32'hBF000000,
                  32'h80000000, 32'h7FC00000);
      send_vector(ReqWrite, 7'h61, 2'd3, 20'h000FF, 32'hC0000000, 32'h3FC00000,
                  32'hBF000000, 32'hFF800000);
      send_vector(ReqWrite, 7'h45, 2'd2, 20'hFFFFF, 32'h7F800000, 32'hFF800000,
                  32'h00000001, 32'hDEADBEEF);
      send_vector(ReqWrite, 7'h1E, 2'd1, 20'h000AA, 32'h12345678, 32'hFEDCBA98,
                  32'h11111111, 32'h22222222);
      send_vector(ReqWrite, 7'h7C, 2'd0, 20'h00003, 32'hC2000000, '1, '1, '1);
      send_vector(ReqRead, 7'h23, 2'd3, SrcPassPrefix, '0, '0, '0, '0);
      send_vector(ReqRead, 7'h03, 2'd3, SrcPassPrefix, '0, '0, '0, '0);
      send_vector(ReqRead, 7'h61, 2'd1, SrcPassPrefix, '0, '0, '0, '0);
      send_vector(ReqRead, 7'h45, 2'd2, 20'h5A5A5, '0, '0, '0, '0);
      send_vector(ReqRead, 7'h1E, 2'd0, 20'h00000, '0, '0, '0, '0);
      send_vector(ReqRead, 7'h7C, 2'd0, 20'h11100, '0, '0, '0, '0);

      for (int i = 0; i < RandomItems; i++) begin
         if (i == RandomItems - 50) calm = 1'b1;
         send_random();
      end
      req_if.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered %0d reads and %0d writes with random prefixes, clamps and codes.",
               read_count, write_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
